// ===== rtl/cjm_pkg.sv =====
`default_nettype none
package cjm_pkg;

  localparam int JOB_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int CNT_W       = $clog2(JOB_SLOTS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int JOB_W       = 32;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [3:0] ACT_CLEAR = 4'd6;

  localparam logic [2:0] WDAY_SUN  = 3'd0;
  localparam logic [2:0] WDAY_SAT  = 3'd6;
  localparam logic [2:0] WDAY_ALT_SUN = 3'd7;
  localparam logic [3:0] MON_MAR   = 4'd3;
  localparam logic [3:0] MON_OCT   = 4'd10;
  localparam logic [5:0] LAST_WEEK_DAY = 6'd25;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;
  localparam logic [4:0] SWITCH_HOUR_MAR = 5'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic [3:0] action;
    logic [4:0] mask;
    logic [2:0] wday;
    logic [3:0] month;
    logic [4:0] mday;
    logic [5:0] minute;
    logic [4:0] hour;
  } job_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] mday;
    logic [3:0] month;
    logic [2:0] wday;
  } tick_t;

  typedef struct packed {
    logic [3:0] job_index;
    logic [3:0] fired_action;
    logic       dst_active;
    logic [4:0] job_count;
    logic       accepted;
    logic       last;
  } res_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd2:  len = 5'd29;
      4'd4:  len = 5'd30;
      4'd6:  len = 5'd30;
      4'd9:  len = 5'd30;
      4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic job_hit(input job_t j, input tick_t t);
    logic [2:0] jw;
    jw = (j.wday == WDAY_ALT_SUN) ? WDAY_SUN : j.wday;
    return (j.mask[0] || (j.hour   == t.hour))   &&
           (j.mask[1] || (j.minute == t.minute)) &&
           (j.mask[2] || (j.mday   == t.mday))   &&
           (j.mask[3] || (j.month  == t.month))  &&
           (j.mask[4] || (jw       == t.wday));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cjm_ifs.sv =====
`default_nettype none
interface cjm_in_if ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [4:0] mday;
  logic [3:0] month;
  logic [2:0] wday;
  logic [4:0] wildcard_mask;
  logic [3:0] action_code;

  modport source (output valid, command, hour, minute, mday, month,
                  wday, wildcard_mask, action_code, input ready);
  modport sink (input valid, command, hour, minute, mday, month,
                wday, wildcard_mask, action_code, output ready);
endinterface

interface cjm_out_if ();
  logic       valid;
  logic       ready;
  logic [3:0] job_index;
  logic [3:0] fired_action;
  logic       dst_active;
  logic [4:0] job_count;
  logic       accepted;
  logic       last;

  modport source (output valid, job_index, fired_action, dst_active, job_count,
                  accepted, last, input ready);
  modport sink (input valid, job_index, fired_action, dst_active, job_count,
                accepted, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/cron_job_matcher_with_dst.sv =====
// Add and clear commands give their word in the cycle after they are taken.
// A tick scans the job table out of a one-port-read RAM, one job per cycle
// while the output register can take the results of the scan.
// Input is taken only while no scan runs and the output register can accept.
// Synchronous active-low reset empties the table and clears all control state.
`default_nettype none
module cron_job_matcher_with_dst import cjm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cjm_in_if.sink     in_ch,
  cjm_out_if.source  out_ch
);
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  rd_i_r, rd_i_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              cmp_last_r, cmp_last_nxt;
  logic [NRES_W-1:0] n_r, n_nxt;
  logic              pend_v_r, pend_v_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  tick_t             time_r, time_nxt;
  logic              dst_r, dst_nxt;

  tick_t             t_in, t_adj;
  logic              t_dst;
  job_t              new_job;
  job_t              entry;
  logic [JOB_W-1:0]  rd_data;
  logic              ram_we, ram_re;
  logic              can_push, push, stall, end_now, hit, is_clr, room;
  res_t              push_res;

  assign t_in = '{hour: in_ch.hour, minute: in_ch.minute, mday: in_ch.mday,
                  month: in_ch.month, wday: in_ch.wday};

  assign new_job = '{action: in_ch.action_code, mask: in_ch.wildcard_mask,
                     wday: in_ch.wday, month: in_ch.month,
                     mday: in_ch.mday, minute: in_ch.minute,
                     hour: in_ch.hour};

  cjm_dst u_dst (
    .t_in  (t_in),
    .t_out (t_adj),
    .dst   (t_dst)
  );

  cjm_ram #(.WIDTH(JOB_W), .DEPTH(JOB_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (held_r[IDX_W-1:0]),
    .wdata (new_job),
    .re    (ram_re),
    .raddr (rd_i_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign entry    = job_t'(rd_data);
  assign hit      = job_hit(entry, time_r);
  assign is_clr   = (entry.action == ACT_CLEAR);
  assign can_push = !out_v_r || out_ch.ready;
  assign room     = held_r < CNT_W'(JOB_SLOTS);

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    rd_i_nxt     = rd_i_r;
    cmp_v_nxt    = cmp_v_r;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_last_nxt = cmp_last_r;
    n_nxt        = n_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    time_nxt     = time_r;
    dst_nxt      = dst_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    push         = 1'b0;
    push_res     = '0;
    stall        = 1'b0;
    end_now      = 1'b0;
    in_ch.ready  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = can_push;
        if (in_ch.valid && can_push) begin
          case (in_ch.command)
            CMD_ADD: begin
              push              = 1'b1;
              push_res.last     = 1'b1;
              push_res.accepted = room;
              if (room) begin
                ram_we             = 1'b1;
                held_nxt           = held_r + CNT_W'(1);
                push_res.job_count = 5'(held_r + CNT_W'(1));
              end else begin
                push_res.job_count = 5'(held_r);
              end
            end
            CMD_CLEAR: begin
              push          = 1'b1;
              push_res.last = 1'b1;
              held_nxt      = '0;
            end
            CMD_TICK: begin
              time_nxt   = t_adj;
              dst_nxt    = t_dst;
              rd_i_nxt   = '0;
              cmp_v_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              n_nxt      = '0;
              if (held_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        stall = cmp_v_r && pend_v_r && !can_push;
        if (!stall) begin
          if (cmp_v_r) begin
            if (hit) begin
              if (is_clr) begin
                held_nxt = '0;
                end_now  = 1'b1;
              end
              if (n_r < NRES_W'(MAX_RESULTS)) begin
                if (pend_v_r) begin
                  push     = 1'b1;
                  push_res = pend_r;
                end
                pend_v_nxt            = 1'b1;
                pend_nxt.job_index    = 4'(cmp_idx_r);
                pend_nxt.fired_action = entry.action;
                pend_nxt.dst_active   = dst_r;
                pend_nxt.job_count    = is_clr ? 5'd0 : 5'(held_r);
                pend_nxt.accepted     = 1'b0;
                pend_nxt.last         = 1'b0;
                n_nxt                 = n_r + NRES_W'(1);
              end
            end
            if (cmp_last_r) begin
              end_now = 1'b1;
            end
          end
          if (end_now) begin
            state_nxt = S_FLUSH;
            cmp_v_nxt = 1'b0;
          end else if (rd_i_r < held_r) begin
            ram_re       = 1'b1;
            cmp_v_nxt    = 1'b1;
            cmp_idx_nxt  = rd_i_r[IDX_W-1:0];
            cmp_last_nxt = (rd_i_r + CNT_W'(1)) == held_r;
            rd_i_nxt     = rd_i_r + CNT_W'(1);
          end else begin
            cmp_v_nxt = 1'b0;
          end
        end
      end

      S_FLUSH: begin
        if (pend_v_r) begin
          if (can_push) begin
            push          = 1'b1;
            push_res      = pend_r;
            push_res.last = 1'b1;
            pend_v_nxt    = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push) begin
      out_v_nxt = 1'b1;
      out_nxt   = push_res;
    end else begin
      out_v_nxt = out_v_r && !out_ch.ready;
      out_nxt   = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      held_r   <= '0;
      rd_i_r   <= '0;
      cmp_v_r  <= 1'b0;
      n_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      rd_i_r   <= rd_i_nxt;
      cmp_v_r  <= cmp_v_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    time_r     <= time_nxt;
    dst_r      <= dst_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.job_index    = out_r.job_index;
  assign out_ch.fired_action = out_r.fired_action;
  assign out_ch.dst_active   = out_r.dst_active;
  assign out_ch.job_count    = out_r.job_count;
  assign out_ch.accepted     = out_r.accepted;
  assign out_ch.last         = out_r.last;
endmodule
`default_nettype wire

// ===== rtl/cjm_ram.sv =====
`default_nettype none
module cjm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/cjm_dst.sv =====
`default_nettype none
module cjm_dst import cjm_pkg::*; (
  input  wire tick_t t_in,
  output tick_t      t_out,
  output logic       dst
);
  logic [2:0] wd;
  logic       late_week;
  logic [5:0] h6;
  logic [5:0] md6;

  always_comb begin
    wd        = (t_in.wday == WDAY_ALT_SUN) ? WDAY_SUN : t_in.wday;
    late_week = {1'b0, t_in.mday} >= ({3'b000, wd} + LAST_WEEK_DAY);
    if (t_in.month < MON_MAR || t_in.month > MON_OCT) begin
      dst = 1'b0;
    end else if (t_in.month > MON_MAR && t_in.month < MON_OCT) begin
      dst = 1'b1;
    end else if (t_in.month == MON_MAR) begin
      dst = late_week && ((wd != WDAY_SUN) || (t_in.hour >= SWITCH_HOUR_MAR));
    end else begin
      dst = late_week ? ((wd == WDAY_SUN) && (t_in.hour == 5'd0)) : 1'b1;
    end

    t_out      = t_in;
    t_out.wday = wd;
    h6         = {1'b0, t_in.hour} + 6'd1;
    md6        = {1'b0, t_in.mday} + 6'd1;
    if (dst) begin
      if (h6 >= HOURS_PER_DAY) begin
        t_out.hour = 5'(h6 - HOURS_PER_DAY);
        t_out.wday = (wd == WDAY_SAT) ? WDAY_SUN : wd + 3'd1;
        if (md6 > {1'b0, month_len(t_in.month)}) begin
          t_out.mday  = 5'd1;
          t_out.month = t_in.month + 4'd1;
        end else begin
          t_out.mday = md6[4:0];
        end
      end else begin
        t_out.hour = h6[4:0];
      end
    end
  end
endmodule
`default_nettype wire
